FILE: rtl/upq_pkg.sv
// shared types and constants for the unsorted array priority queue
// no dependencies; imported by upq_ctrl, upq_datapath and the top level
`default_nettype none

package upq_pkg;

  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned PRIO_BITS   = 16;
  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned COUNT_BITS  = 7;

  // command codes; codes above query act as query
  localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_CHANGE  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_QUERY   = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY      = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_URGENT = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 3'd4;

  typedef struct packed {
    logic [CMD_BITS-1:0]         cmd;
    logic [KEY_BITS-1:0]         key_value;
    logic signed [PRIO_BITS-1:0] prio;
  } in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic [KEY_BITS-1:0]         removed_value;
    logic [KEY_BITS-1:0]         head_value;
    logic signed [PRIO_BITS-1:0] head_prio;
    logic [COUNT_BITS-1:0]       entry_count;
    logic                        is_empty;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]         value;
    logic signed [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_MIN,
    S_MATCH,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_EXEC,
    DP_SHIFT,
    DP_MIN,
    DP_MATCH,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                count_zero;
    logic                sweep_done;
    logic                hit;
    logic                out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/upq_datapath.sv
// datapath: entry memory, fill count, sweep pointer, cached head and output register
// depends on upq_pkg; driven by upq_ctrl through ctl_t, reports through sts_t
`default_nettype none

module upq_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upq_pkg::in_t  in_data_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output upq_pkg::out_t out_data_o,
  input  upq_pkg::ctl_t ctl_i,
  output upq_pkg::sts_t sts_o
);
  import upq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  entry_t                      mem_q [CAPACITY];
  in_t                         req_q;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic                        pend_q;
  logic [AW-1:0]               pend_idx_q;
  entry_t                      rd_q;
  logic [KEY_BITS-1:0]         head_value_q, head_value_d;
  logic signed [PRIO_BITS-1:0] head_prio_q, head_prio_d;
  logic [AW-1:0]               head_idx_q, head_idx_d;
  logic [STATUS_BITS-1:0]      status_q, status_d;
  logic [KEY_BITS-1:0]         removed_q, removed_d;
  logic                        out_valid_q;
  out_t                        out_q, out_next;

  logic                        sweep, rd_en, sweep_done, hit, out_free, emit;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  entry_t                      wr_data;
  logic signed [PRIO_BITS-1:0] rd_prio, req_prio;
  logic                        enq_better, min_better, chg_better;

  assign rd_prio  = rd_q.prio;
  assign req_prio = req_q.prio;

  assign sweep      = (ctl_i.op == DP_SHIFT) || (ctl_i.op == DP_MIN) || (ctl_i.op == DP_MATCH);
  assign rd_en      = sweep && (idx_q < count_q);
  assign rd_addr    = idx_q[AW-1:0];
  assign sweep_done = !rd_en && !pend_q;
  assign hit        = (ctl_i.op == DP_MATCH) && pend_q && (rd_q.value == req_q.key_value);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (ctl_i.op == DP_EMIT) && out_free;

  // ordering is priority, then value, then position in the array
  assign enq_better = (req_prio < head_prio_q) ||
                      ((req_prio == head_prio_q) && (req_q.key_value < head_value_q));
  assign min_better = (rd_prio < head_prio_q) ||
                      ((rd_prio == head_prio_q) && (rd_q.value < head_value_q));
  assign chg_better = (req_prio < head_prio_q) ||
                      ((req_prio == head_prio_q) && ((rd_q.value < head_value_q) ||
                       ((rd_q.value == head_value_q) && (pend_idx_q < head_idx_q))));

  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    head_value_d = head_value_q;
    head_prio_d  = head_prio_q;
    head_idx_d   = head_idx_q;
    status_d     = status_q;
    removed_d    = removed_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_data      = '{value: req_q.key_value, prio: req_prio};
    if (rd_en) begin
      idx_d = idx_q + 1'b1;
    end
    unique case (ctl_i.op)
      DP_EXEC: begin
        status_d  = STATUS_OK;
        removed_d = '0;
        priority if (req_q.cmd == CMD_ENQUEUE) begin
          if (count_q == CW'(CAPACITY)) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if ((count_q == '0) || enq_better) begin
              head_value_d = req_q.key_value;
              head_prio_d  = req_prio;
              head_idx_d   = count_q[AW-1:0];
            end
          end
        end else if (req_q.cmd == CMD_DEQUEUE) begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            // the head is the entry that leaves; later entries move down from there
            removed_d = head_value_q;
            idx_d     = CW'(head_idx_q) + 1'b1;
          end
        end else if (req_q.cmd == CMD_CHANGE) begin
          idx_d = '0;
          if (count_q == '0) begin
            status_d = STATUS_NOT_FOUND;
          end
        end else if (req_q.cmd == CMD_CLEAR) begin
          count_d = '0;
        end else begin
          // query and the unused codes change nothing
        end
      end
      DP_SHIFT: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_q - 1'b1;
          wr_data = rd_q;
        end
        if (sweep_done) begin
          count_d = count_q - 1'b1;
          idx_d   = '0;
        end
      end
      DP_MIN: begin
        if (pend_q && ((pend_idx_q == '0) || min_better)) begin
          head_value_d = rd_q.value;
          head_prio_d  = rd_prio;
          head_idx_d   = pend_idx_q;
        end
      end
      DP_MATCH: begin
        if (hit) begin
          if (rd_prio >= req_prio) begin
            wr_en    = 1'b1;
            wr_addr  = pend_idx_q;
            wr_data  = '{value: rd_q.value, prio: req_prio};
            status_d = STATUS_OK;
            if (pend_idx_q == head_idx_q) begin
              head_prio_d = req_prio;
            end else if (chg_better) begin
              head_value_d = rd_q.value;
              head_prio_d  = req_prio;
              head_idx_d   = pend_idx_q;
            end
          end else begin
            status_d = STATUS_NOT_URGENT;
          end
        end else if (sweep_done) begin
          status_d = STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_next.status        = status_q;
    out_next.removed_value = removed_q;
    out_next.head_value    = (count_q == '0) ? '0 : head_value_q;
    out_next.head_prio     = (count_q == '0) ? '0 : head_prio_q;
    out_next.entry_count   = COUNT_BITS'(count_q);
    out_next.is_empty      = (count_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= rd_en;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_LOAD) begin
      req_q <= in_data_i;
    end
    pend_idx_q   <= rd_addr;
    head_value_q <= head_value_d;
    head_prio_q  <= head_prio_d;
    head_idx_q   <= head_idx_d;
    status_q     <= status_d;
    removed_q    <= removed_d;
    if (emit) begin
      out_q <= out_next;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.cmd        = req_q.cmd;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.sweep_done = sweep_done;
  assign sts_o.hit        = hit;
  assign sts_o.out_free   = out_free;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_idx_q) < count_q))
    else $error("read of a slot at or above the fill count");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctl_i.op == DP_MIN) && sweep_done && (count_q != '0)) |=> (CW'(head_idx_q) < count_q))
    else $error("head index outside the filled slots after rescan");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result word not presented after emit");

endmodule

`default_nettype wire

FILE: rtl/upq_ctrl.sv
// controller state machine: sequences load, execute, shift, rescan, match and emit
// depends on upq_pkg; commands upq_datapath through ctl_t
`default_nettype none

module upq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  upq_pkg::sts_t sts_i,
  output upq_pkg::ctl_t ctl_o
);
  import upq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o.op   = DP_IDLE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.op = DP_LOAD;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.op = DP_EXEC;
        priority if ((sts_i.cmd == CMD_DEQUEUE) && !sts_i.count_zero) begin
          state_d = S_SHIFT;
        end else if ((sts_i.cmd == CMD_CHANGE) && !sts_i.count_zero) begin
          state_d = S_MATCH;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        ctl_o.op = DP_SHIFT;
        if (sts_i.sweep_done) begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        ctl_o.op = DP_MIN;
        if (sts_i.sweep_done) begin
          state_d = S_FINISH;
        end
      end
      S_MATCH: begin
        ctl_o.op = DP_MATCH;
        if (sts_i.hit || sts_i.sweep_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl_o.op = DP_EMIT;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/unsorted_array_priority_queue_core.sv
// Min-priority queue over an insertion-ordered array of (value, priority) entries.
// Input channel: in_valid_i / in_stall_o carry one command word (enqueue, dequeue,
// change priority, clear, query). Output channel: out_valid_o / out_stall_i carry
// one result word per command: status, removed value, head, entry count, empty flag.
// One command is worked at a time; the entry memory has a single read and a
// single write port and every sweep reads one slot per cycle.
//   enqueue, clear, query, and any command that fails at once: load, execute, emit
//   change priority: load, execute, linear search for the first match, emit
//   dequeue: load, execute, shift of the later entries, rescan for the new head, emit
// The input side takes a new word while the previous result still waits in the
// output register; a stalled result holds its word and only holds up the end of
// the following command.
// Reset empties the queue and drops any pending result; the entry memory is not
// cleared and needs no start-up pass.
// Depends on upq_pkg, upq_ctrl and upq_datapath.
`default_nettype none

module unsorted_array_priority_queue_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  upq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output upq_pkg::out_t out_data_o
);
  import upq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  upq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  upq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

FILE: test/tb_unsorted_array_priority_queue_core.sv
// self-checking testbench for unsorted_array_priority_queue_core: a table of directed
// commands, then random command streams checked against a queue predictor in this file
// depends on upq_pkg and the core rtl only
module tb_unsorted_array_priority_queue_core;
  import upq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS  = 260;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES  = 200;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_t  cmd_word = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result_word;

  // predictor state
  logic [KEY_BITS-1:0]         model_values [QUEUE_DEPTH];
  logic signed [PRIO_BITS-1:0] model_prios  [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0]       model_fill = '0;

  out_t        expected_results [$];
  out_t        oldest_expected;
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  unsorted_array_priority_queue_core #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_valid),
    .in_stall_o (cmd_stall),
    .in_data_i  (cmd_word),
    .out_valid_o(result_valid),
    .out_stall_i(result_stall),
    .out_data_o (result_word)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic in_t queue_word(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
                                     logic [PRIO_BITS-1:0] prio);
    in_t w;
    w.cmd = cmd;
    w.key_value = key;
    w.prio = prio;
    return w;
  endfunction

  function automatic out_t queue_result(logic [STATUS_BITS-1:0] status,
                                        logic [KEY_BITS-1:0] removed,
                                        logic [KEY_BITS-1:0] head_value,
                                        logic [PRIO_BITS-1:0] head_prio,
                                        logic [COUNT_BITS-1:0] count);
    out_t r;
    r.status = status;
    r.removed_value = removed;
    r.head_value = head_value;
    r.head_prio = head_prio;
    r.entry_count = count;
    r.is_empty = (count == 0);
    return r;
  endfunction

  // least priority wins, then the smaller value, then the earlier slot
  function automatic int unsigned head_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < model_fill; i++) begin
      if (model_prios[i] < model_prios[best] ||
          (model_prios[i] == model_prios[best] && model_values[i] < model_values[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic out_t predict_queue_step(in_t word);
    out_t r;
    int unsigned h;
    bit matched;
    logic signed [PRIO_BITS-1:0] new_prio;
    r = '0;
    r.status = STATUS_OK;
    matched = 1'b0;
    new_prio = $signed(word.prio);
    case (word.cmd)
      CMD_ENQUEUE: begin
        if (model_fill >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          model_values[model_fill] = word.key_value;
          model_prios[model_fill] = new_prio;
          model_fill++;
        end
      end
      CMD_DEQUEUE: begin
        if (model_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          h = head_slot();
          r.removed_value = model_values[h];
          // later entries move down one slot, order kept
          for (int unsigned i = h; i + 1 < model_fill; i++) begin
            model_values[i] = model_values[i + 1];
            model_prios[i] = model_prios[i + 1];
          end
          model_fill--;
        end
      end
      CMD_CHANGE: begin
        r.status = STATUS_NOT_FOUND;
        for (int unsigned i = 0; i < model_fill; i++) begin
          if (!matched && model_values[i] == word.key_value) begin
            matched = 1'b1;
            if (model_prios[i] >= new_prio) begin
              model_prios[i] = new_prio;
              r.status = STATUS_OK;
            end else begin
              r.status = STATUS_NOT_URGENT;
            end
          end
        end
      end
      CMD_CLEAR: model_fill = '0;
      default: ;
    endcase
    if (model_fill == 0) begin
      r.is_empty = 1'b1;
    end else begin
      h = head_slot();
      r.head_value = model_values[h];
      r.head_prio = model_prios[h];
    end
    r.entry_count = model_fill;
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] random_key();
    if ($urandom_range(0, 1)) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  function automatic logic [PRIO_BITS-1:0] random_prio();
    case ($urandom_range(0, 4))
      0, 1: return $urandom_range(0, 8) - 4;
      2, 3: return $urandom();
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic in_t random_queue_word();
    int unsigned pick;
    int unsigned s;
    logic [PRIO_BITS-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 40) return queue_word(CMD_ENQUEUE, random_key(), random_prio());
    if (pick < 65) return queue_word(CMD_DEQUEUE, $urandom(), $urandom());
    if (pick < 90) begin
      // mostly aim at a stored value, half the time with a priority near the stored one
      if (model_fill != 0 && $urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, model_fill - 1);
        case ($urandom_range(0, 3))
          0: p = model_prios[s] - $urandom_range(0, 2);
          1: p = model_prios[s] + 1;
          default: p = random_prio();
        endcase
        return queue_word(CMD_CHANGE, model_values[s], p);
      end
      return queue_word(CMD_CHANGE, random_key(), random_prio());
    end
    if (pick < 92) return queue_word(CMD_CLEAR, $urandom(), $urandom());
    return queue_word($urandom_range(CMD_QUERY, {CMD_BITS{1'b1}}), $urandom(), $urandom());
  endfunction

  task automatic add_row(input in_t word, input bit typed, input out_t want);
    stim_row_t r;
    r.word = word;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // valid holds until the word is taken; predictor runs at the accepting edge
  task automatic offer_word(input in_t word, input bit typed, input out_t typed_result);
    out_t predicted;
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_gap_pct);
    end
    cmd_valid <= 1'b1;
    cmd_word <= word;
    do @(posedge clk_i); while (cmd_stall !== 1'b0);
    predicted = predict_queue_step(word);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (pressure_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid === 1'b1 && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %p", $time, result_word);
        mismatches++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("status", oldest_expected.status, result_word.status);
        check_field("removed_value", oldest_expected.removed_value, result_word.removed_value);
        check_field("head_value", oldest_expected.head_value, result_word.head_value);
        check_field("head_prio", longint'(oldest_expected.head_prio),
                    longint'($signed(result_word.head_prio)));
        check_field("entry_count", oldest_expected.entry_count, result_word.entry_count);
        check_field("is_empty", oldest_expected.is_empty, result_word.is_empty);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    // queue starts empty
    add_row(queue_word(CMD_QUERY, '0, '0), 1, queue_result(STATUS_OK, 0, 0, 0, 0));
    add_row(queue_word(CMD_DEQUEUE, '0, '0), 1, queue_result(STATUS_EMPTY, 0, 0, 0, 0));
    add_row(queue_word(CMD_CHANGE, 32'd7, '0), 1, queue_result(STATUS_NOT_FOUND, 0, 0, 0, 0));
    add_row(queue_word(CMD_ENQUEUE, 32'hFFFF_FFFF, 16'h7FFF), 1,
            queue_result(STATUS_OK, 0, 32'hFFFF_FFFF, 16'h7FFF, 1));
    add_row(queue_word(CMD_ENQUEUE, 32'h0, 16'h8000), 1,
            queue_result(STATUS_OK, 0, 32'h0, 16'h8000, 2));
    // ties on priority, then on value too
    add_row(queue_word(CMD_ENQUEUE, 32'd5, 16'h8000), 0, '0);
    add_row(queue_word(CMD_ENQUEUE, 32'h0, 16'h8000), 0, '0);
    // raising a priority is refused, an equal one is taken
    add_row(queue_word(CMD_CHANGE, 32'd5, 16'h7FFF), 0, '0);
    add_row(queue_word(CMD_CHANGE, 32'hFFFF_FFFF, 16'h7FFF), 0, '0);
    add_row(queue_word(CMD_CHANGE, 32'h1234_5678, 16'h0), 0, '0);
    add_row(queue_word(CMD_CHANGE, 32'hFFFF_FFFF, 16'h8000), 0, '0);
    add_row(queue_word(CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF), 0, '0);
    add_row(queue_word(CMD_DEQUEUE, '0, '0), 0, '0);
    add_row(queue_word(CMD_ENQUEUE, 32'hAAAA_AAAA, 16'h5555), 0, '0);
    add_row(queue_word(CMD_ENQUEUE, 32'h5555_5555, 16'hAAAA), 0, '0);
    add_row(queue_word(CMD_DEQUEUE, '0, '0), 0, '0);
    // unused codes behave as query
    add_row(queue_word(3'd5, 32'hFFFF_FFFF, 16'hFFFF), 0, '0);
    add_row(queue_word(3'd6, '0, '0), 0, '0);
    add_row(queue_word(3'd7, 32'h8000_0001, 16'h8001), 0, '0);
    add_row(queue_word(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF), 1, queue_result(STATUS_OK, 0, 0, 0, 0));
    add_row(queue_word(CMD_QUERY, '0, '0), 1, queue_result(STATUS_OK, 0, 0, 0, 0));
    add_row(queue_word(CMD_CLEAR, '0, '0), 1, queue_result(STATUS_OK, 0, 0, 0, 0));
    add_row(queue_word(CMD_DEQUEUE, '0, '0), 1, queue_result(STATUS_EMPTY, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) offer_word(directed_rows[i].word, directed_rows[i].typed,
                                          directed_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_gap_pct = 57; recv_stall_pct = 0;  end
        2: begin sender_gap_pct = 0;  recv_stall_pct = 57; end
        default: begin sender_gap_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (phase == 0 && n == RANDOM_ITEMS / 2) pressure_req = 1'b1;
        offer_word(random_queue_word(), 0, '0);
      end
      // fill to capacity and push past it, then empty again
      while (model_fill < QUEUE_DEPTH)
        offer_word(queue_word(CMD_ENQUEUE, random_key(), random_prio()), 0, '0);
      repeat (2) offer_word(queue_word(CMD_ENQUEUE, random_key(), random_prio()), 0, '0);
      if (phase % 2 == 0) begin
        while (model_fill != 0) offer_word(queue_word(CMD_DEQUEUE, $urandom(), $urandom()), 0, '0);
        offer_word(queue_word(CMD_DEQUEUE, $urandom(), $urandom()), 0, '0);
      end else begin
        offer_word(queue_word(CMD_CLEAR, $urandom(), $urandom()), 0, '0);
      end
    end
    cmd_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: unsorted_array_priority_queue_core.f
rtl/upq_pkg.sv
rtl/upq_datapath.sv
rtl/upq_ctrl.sv
rtl/unsorted_array_priority_queue_core.sv
test/tb_unsorted_array_priority_queue_core.sv
